>>> design/mco_pkg.sv
// Shared types and constants for the matrix chain ordering block.
package mco_pkg;

  localparam int IDX_W  = 4;
  localparam int COST_W = 28;

  localparam logic [COST_W-1:0] COST_MAX = '1;

  typedef struct packed {
    logic             dim_we;
    logic             dim_re;
    logic [IDX_W-1:0] dim_addr;
    logic             cap_pa;
    logic             cap_pj;
    logic             issue;
    logic [IDX_W-1:0] idx_i;
    logic [IDX_W-1:0] idx_j;
    logic [IDX_W-1:0] idx_k;
    logic             emit_pair;
    logic             emit_single;
    logic             end_run;
    logic             ovf;
  } cmd_t;

  typedef struct packed {
    logic pipe_busy;
  } sts_t;

endpackage

>>> design/matrix_chain_order.sv
// Top level of the matrix chain ordering block.
//
//   channel  ports                                   beat taken when
//   -------  --------------------------------------  ----------------------
//   input    in_dimension, in_final_dimension        start && !busy
//   result   out_first_matrix .. out_overflow        out_valid (one cycle)
//
// Dimension beats are taken back to back while the block is idle. After the
// final beat of a chain of n matrices the controller walks every interval:
// per interval it fetches the outer dimensions in S_OPEN and S_OPEN2, issues
// each split into the cost pipeline in S_SWEEP and waits in S_DRAIN for the
// pipeline to empty before it gives the result of that interval.
// For two or more matrices busy rises after the final beat and drops in the
// cycle the last result shows; a shorter chain gives its one result the cycle
// after the final beat without raising busy. rst_n is synchronous; no
// clearing pass is needed. Results cannot be held off.
module matrix_chain_order #(
  parameter int MAX_MATRICES = 10,
  parameter int DIM_WIDTH    = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [DIM_WIDTH-1:0]       in_dimension,
  input  logic                       in_final_dimension,
  output logic                       out_valid,
  output logic [mco_pkg::IDX_W-1:0]  out_first_matrix,
  output logic [mco_pkg::IDX_W-1:0]  out_last_matrix,
  output logic [mco_pkg::COST_W-1:0] out_min_cost,
  output logic [mco_pkg::IDX_W-1:0]  out_best_split,
  output logic                       out_end_of_run,
  output logic                       out_overflow
);
  import mco_pkg::*;

  cmd_t cmd;
  sts_t sts;

  mco_ctrl #(
    .MAX_MATRICES(MAX_MATRICES)
  ) u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .in_final_dimension(in_final_dimension),
    .busy              (busy),
    .cmd               (cmd),
    .sts               (sts)
  );

  mco_dpath #(
    .MAX_MATRICES(MAX_MATRICES),
    .DIM_WIDTH   (DIM_WIDTH)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_dimension    (in_dimension),
    .cmd             (cmd),
    .sts             (sts),
    .out_valid       (out_valid),
    .out_first_matrix(out_first_matrix),
    .out_last_matrix (out_last_matrix),
    .out_min_cost    (out_min_cost),
    .out_best_split  (out_best_split),
    .out_end_of_run  (out_end_of_run),
    .out_overflow    (out_overflow)
  );

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_end_of_run |-> !busy)
    else $error("end of run shown while busy");

  a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_end_of_run |-> busy)
    else $error("mid-run result while idle");

  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && !in_final_dimension |=> !out_valid)
    else $error("result after a non-final beat");

  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_first_matrix <= out_last_matrix)
    else $error("interval bounds reversed");

endmodule

>>> design/mco_ctrl.sv
// Controller: loads dimensions and sequences the interval and split loops.
module mco_ctrl #(
  parameter int MAX_MATRICES = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        in_final_dimension,
  output logic        busy,
  output mco_pkg::cmd_t cmd,
  input  mco_pkg::sts_t sts
);
  import mco_pkg::*;

  localparam int SIDE = MAX_MATRICES + 1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_OPEN  = 3'd1;
  localparam logic [2:0] S_OPEN2 = 3'd2;
  localparam logic [2:0] S_SWEEP = 3'd3;
  localparam logic [2:0] S_DRAIN = 3'd4;

  logic [2:0]       state_r, state_nxt;
  logic [IDX_W-1:0] cnt_r, cnt_nxt;
  logic             ovf_r, ovf_nxt;
  logic [IDX_W-1:0] n_r, n_nxt;
  logic [IDX_W-1:0] t_r, t_nxt;
  logic [IDX_W-1:0] i_r, i_nxt;
  logic [IDX_W-1:0] k_r, k_nxt;
  logic [IDX_W-1:0] j;
  logic [IDX_W-1:0] cnt_new;
  logic             room;

  assign j    = i_r + t_r;
  assign room = (cnt_r < IDX_W'(SIDE));
  assign cnt_new = room ? cnt_r + 1'b1 : cnt_r;
  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    ovf_nxt   = ovf_r;
    n_nxt     = n_r;
    t_nxt     = t_r;
    i_nxt     = i_r;
    k_nxt     = k_r;
    cmd             = '0;
    cmd.idx_i       = i_r;
    cmd.idx_j       = j;
    cmd.idx_k       = k_r;
    cmd.ovf         = ovf_r;
    cmd.end_run     = (t_r == n_r - 1'b1);
    case (state_r)
      S_IDLE: begin
        cmd.dim_addr = cnt_r;
        if (start) begin
          cmd.dim_we = room;
          cnt_nxt    = cnt_new;
          ovf_nxt    = ovf_r | ~room;
          if (in_final_dimension) begin
            if (cnt_new < IDX_W'(3)) begin
              cmd.emit_single = 1'b1;
              cmd.ovf         = ovf_r | ~room;
              cnt_nxt         = '0;
              ovf_nxt         = 1'b0;
            end else begin
              n_nxt     = cnt_new - 1'b1;
              t_nxt     = IDX_W'(1);
              i_nxt     = IDX_W'(1);
              state_nxt = S_OPEN;
            end
          end
        end
      end
      S_OPEN: begin
        cmd.dim_re   = 1'b1;
        cmd.dim_addr = i_r - 1'b1;
        state_nxt    = S_OPEN2;
      end
      S_OPEN2: begin
        cmd.dim_re   = 1'b1;
        cmd.dim_addr = j;
        cmd.cap_pa   = 1'b1;
        k_nxt        = i_r;
        state_nxt    = S_SWEEP;
      end
      S_SWEEP: begin
        cmd.dim_re   = 1'b1;
        cmd.dim_addr = k_r;
        cmd.issue    = 1'b1;
        cmd.cap_pj   = (k_r == i_r);
        k_nxt        = k_r + 1'b1;
        if (k_r + 1'b1 == j) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!sts.pipe_busy) begin
          cmd.emit_pair = 1'b1;
          if (j < n_r) begin
            i_nxt     = i_r + 1'b1;
            state_nxt = S_OPEN;
          end else if (t_r + 1'b1 < n_r) begin
            t_nxt     = t_r + 1'b1;
            i_nxt     = IDX_W'(1);
            state_nxt = S_OPEN;
          end else begin
            cnt_nxt   = '0;
            ovf_nxt   = 1'b0;
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      ovf_r   <= 1'b0;
      n_r     <= '0;
      t_r     <= '0;
      i_r     <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ovf_r   <= ovf_nxt;
      n_r     <= n_nxt;
      t_r     <= t_nxt;
      i_r     <= i_nxt;
      k_r     <= k_nxt;
    end
  end

endmodule

>>> design/mco_dpath.sv
// Datapath: dimension and cost memories, split cost pipeline, result registers.
module mco_dpath #(
  parameter int MAX_MATRICES = 10,
  parameter int DIM_WIDTH    = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [DIM_WIDTH-1:0]          in_dimension,
  input  mco_pkg::cmd_t                 cmd,
  output mco_pkg::sts_t                 sts,
  output logic                          out_valid,
  output logic [mco_pkg::IDX_W-1:0]     out_first_matrix,
  output logic [mco_pkg::IDX_W-1:0]     out_last_matrix,
  output logic [mco_pkg::COST_W-1:0]    out_min_cost,
  output logic [mco_pkg::IDX_W-1:0]     out_best_split,
  output logic                          out_end_of_run,
  output logic                          out_overflow
);
  import mco_pkg::*;

  localparam int SIDE = MAX_MATRICES + 1;
  localparam int DAW  = $clog2(SIDE);
  localparam int CAW  = $clog2(SIDE * SIDE);
  localparam int P1W  = 2 * DIM_WIDTH;
  localparam int P2W  = 3 * DIM_WIDTH;
  localparam int SW   = ((P2W > COST_W) ? P2W : COST_W) + 2;

  logic [DIM_WIDTH-1:0] dim_mem [SIDE];
  logic [COST_W-1:0]    cost_mem [SIDE*SIDE];

  logic [DIM_WIDTH-1:0] dim_q_r;
  logic [COST_W-1:0]    ca_q_r, cb_q_r;
  logic [DIM_WIDTH-1:0] pa_r, pj_r;

  logic             v1_r, v2_r, v3_r;
  logic [IDX_W-1:0] k1_r, k2_r, k3_r;
  logic             za1_r, zb1_r;
  logic [P1W-1:0]   prod1_r;
  logic [P2W-1:0]   prod2_r;
  logic [COST_W:0]  cab2_r, cab3_r;

  logic [COST_W-1:0] best_r;
  logic [IDX_W-1:0]  bestk_r;

  logic [CAW-1:0]    addr_a, addr_b, addr_w;
  logic [SW-1:0]     sum;
  logic [COST_W-1:0] cand;

  logic              out_valid_r;
  logic [IDX_W-1:0]  out_first_r, out_last_r, out_split_r;
  logic [COST_W-1:0] out_cost_r;
  logic              out_eor_r, out_ovf_r;

  assign addr_a = CAW'(cmd.idx_i) * CAW'(SIDE) + CAW'(cmd.idx_k);
  assign addr_b = (CAW'(cmd.idx_k) + CAW'(1)) * CAW'(SIDE) + CAW'(cmd.idx_j);
  assign addr_w = CAW'(cmd.idx_i) * CAW'(SIDE) + CAW'(cmd.idx_j);

  assign sum  = SW'(cab3_r) + SW'(prod2_r);
  assign cand = (sum > SW'(COST_MAX)) ? COST_MAX : sum[COST_W-1:0];

  assign sts.pipe_busy = v1_r | v2_r | v3_r;

  always_ff @(posedge clk) begin
    if (cmd.dim_we) begin
      dim_mem[cmd.dim_addr[DAW-1:0]] <= in_dimension;
    end
    if (cmd.dim_re) begin
      dim_q_r <= dim_mem[cmd.dim_addr[DAW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_pair) begin
      cost_mem[addr_w] <= best_r;
    end
    if (cmd.issue) begin
      ca_q_r <= cost_mem[addr_a];
      cb_q_r <= cost_mem[addr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_pa) begin
      pa_r <= dim_q_r;
    end
    if (cmd.cap_pj) begin
      pj_r <= dim_q_r;
    end
    k1_r    <= cmd.idx_k;
    za1_r   <= (cmd.idx_k == cmd.idx_i);
    zb1_r   <= (cmd.idx_k + 1'b1 == cmd.idx_j);
    k2_r    <= k1_r;
    prod1_r <= P1W'(pa_r) * P1W'(dim_q_r);
    cab2_r  <= (za1_r ? (COST_W+1)'(0) : (COST_W+1)'(ca_q_r))
             + (zb1_r ? (COST_W+1)'(0) : (COST_W+1)'(cb_q_r));
    k3_r    <= k2_r;
    prod2_r <= P2W'(prod1_r) * P2W'(pj_r);
    cab3_r  <= cab2_r;
    if (v3_r && ((k3_r == cmd.idx_i) || (cand < best_r))) begin
      best_r  <= cand;
      bestk_r <= k3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= cmd.issue;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit_pair | cmd.emit_single;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_pair) begin
      out_first_r <= cmd.idx_i;
      out_last_r  <= cmd.idx_j;
      out_cost_r  <= best_r;
      out_split_r <= bestk_r;
      out_eor_r   <= cmd.end_run;
      out_ovf_r   <= cmd.ovf;
    end else if (cmd.emit_single) begin
      out_first_r <= IDX_W'(1);
      out_last_r  <= IDX_W'(1);
      out_cost_r  <= '0;
      out_split_r <= '0;
      out_eor_r   <= 1'b1;
      out_ovf_r   <= cmd.ovf;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_first_matrix = out_first_r;
  assign out_last_matrix  = out_last_r;
  assign out_min_cost     = out_cost_r;
  assign out_best_split   = out_split_r;
  assign out_end_of_run   = out_eor_r;
  assign out_overflow     = out_ovf_r;

endmodule

>>> tb/matrix_chain_order_tb.sv
// Self-checking testbench for the matrix chain ordering block: predicted interval results vs. DUT.
module matrix_chain_order_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mco_pkg::*;

  localparam int MAXM      = 10;
  localparam int DW        = 8;
  localparam int SIDE      = MAXM + 1;
  localparam int LIMIT     = 400000;
  localparam int TAIL      = 40;
  localparam int MAX_SHOWN = 30;

  typedef struct {
    logic [DW-1:0] dim;
    logic          fin;
    int            gap;
    bit            drain;
  } beat_t;

  typedef struct {
    logic [IDX_W-1:0]  first_mat;
    logic [IDX_W-1:0]  last_mat;
    logic [COST_W-1:0] cost;
    logic [IDX_W-1:0]  split;
    logic              eor;
    logic              ovf;
  } interval_t;

  logic                clk;
  logic                rst_n;
  logic                start = 1'b0;
  logic                busy;
  logic [DW-1:0]       in_dimension = '0;
  logic                in_final_dimension = 1'b0;
  logic                out_valid;
  logic [IDX_W-1:0]    out_first_matrix;
  logic [IDX_W-1:0]    out_last_matrix;
  logic [COST_W-1:0]   out_min_cost;
  logic [IDX_W-1:0]    out_best_split;
  logic                out_end_of_run;
  logic                out_overflow;

  beat_t     dimension_beats[$];
  interval_t pending_intervals[$];
  beat_t     next_beat;

  logic [DW-1:0] held_dims[0:SIDE-1];
  int            held_count;
  bit            held_ovf;

  int idle_left;
  int beats_taken;
  int chains_closed;
  int overflow_chains;
  int intervals_checked;
  int error_count;
  int cycle_count;

  matrix_chain_order #(
    .MAX_MATRICES(MAXM),
    .DIM_WIDTH   (DW)
  ) u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_dimension      (in_dimension),
    .in_final_dimension(in_final_dimension),
    .out_valid         (out_valid),
    .out_first_matrix  (out_first_matrix),
    .out_last_matrix   (out_last_matrix),
    .out_min_cost      (out_min_cost),
    .out_best_split    (out_best_split),
    .out_end_of_run    (out_end_of_run),
    .out_overflow      (out_overflow)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void absorb_dimension(logic [DW-1:0] dim, logic fin);
    logic [COST_W-1:0] cost_tab[1:MAXM][1:MAXM];
    logic [63:0]       c;
    logic [63:0]       best;
    int                best_k;
    int                n;
    interval_t         r;
    if (held_count < SIDE) begin
      held_dims[held_count] = dim;
      held_count++;
    end else begin
      held_ovf = 1'b1;
    end
    if (!fin) return;
    chains_closed++;
    if (held_ovf) overflow_chains++;
    n = held_count - 1;
    if (n < 2) begin
      r.first_mat = IDX_W'(1);
      r.last_mat  = IDX_W'(1);
      r.cost      = '0;
      r.split     = '0;
      r.eor       = 1'b1;
      r.ovf       = held_ovf;
      pending_intervals.insert(pending_intervals.size(), r);
    end else begin
      for (int i = 1; i <= n; i++) cost_tab[i][i] = '0;
      for (int t = 1; t < n; t++) begin
        for (int i = 1; i + t <= n; i++) begin
          best   = '0;
          best_k = i;
          for (int k = i; k < i + t; k++) begin
            c = 64'(cost_tab[i][k]) + 64'(cost_tab[k+1][i+t]) +
                64'(held_dims[i-1]) * 64'(held_dims[k]) * 64'(held_dims[i+t]);
            if (c > 64'(COST_MAX)) c = 64'(COST_MAX);
            if (k == i || c < best) begin
              best   = c;
              best_k = k;
            end
          end
          cost_tab[i][i+t] = best[COST_W-1:0];
          r.first_mat = IDX_W'(i);
          r.last_mat  = IDX_W'(i + t);
          r.cost      = best[COST_W-1:0];
          r.split     = IDX_W'(best_k);
          r.eor       = (t == n - 1);
          r.ovf       = held_ovf;
          pending_intervals.insert(pending_intervals.size(), r);
        end
      end
    end
    held_count = 0;
    held_ovf   = 1'b0;
  endfunction

  task automatic push_beat(logic [DW-1:0] dim, logic fin, int gap, bit drain);
    beat_t b;
    b.dim   = dim;
    b.fin   = fin;
    b.gap   = gap;
    b.drain = drain;
    dimension_beats.insert(dimension_beats.size(), b);
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [DW-1:0] pick_dimension();
    case ($urandom_range(0, 19))
      0:       return '0;
      1, 2:    return '1;
      3:       return DW'(1);
      default: return DW'($urandom_range(1, (1 << DW) - 1));
    endcase
  endfunction

  task automatic queue_chain(int len, bit drain);
    bit quiet;
    quiet = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < len; i++)
      push_beat(pick_dimension(), i == len - 1, quiet ? 0 : pick_gap(), drain && i == 0);
  endtask

  task automatic flag_mismatch(string msg);
    if (error_count < MAX_SHOWN) $display("[%0t] MISMATCH %s", $realtime, msg);
    error_count++;
  endtask

  // driver: hold start until taken, then advance to the next beat or idle
  always @(posedge clk) begin
    if (!rst_n) begin
      start              <= 1'b0;
      in_dimension       <= '0;
      in_final_dimension <= 1'b0;
      idle_left          = 0;
    end else begin
      if (start && !busy) begin
        absorb_dimension(in_dimension, in_final_dimension);
        beats_taken++;
      end
      if (start && busy) begin
      end else if (idle_left > 0) begin
        idle_left--;
        start <= 1'b0;
      end else if (dimension_beats.size() > 0 &&
                   !(dimension_beats[0].drain && pending_intervals.size() > 0)) begin
        next_beat           = dimension_beats.pop_front();
        in_dimension       <= next_beat.dim;
        in_final_dimension <= next_beat.fin;
        start              <= 1'b1;
        idle_left           = next_beat.gap;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: compare every result beat against the oldest predicted interval
  always @(posedge clk) begin
    interval_t want;
    if (rst_n && out_valid) begin
      if (pending_intervals.size() == 0) begin
        flag_mismatch($sformatf("unexpected result %0d..%0d cost %0d",
                                out_first_matrix, out_last_matrix, out_min_cost));
      end else begin
        want = pending_intervals.pop_front();
        intervals_checked++;
        if (out_first_matrix !== want.first_mat)
          flag_mismatch($sformatf("first_matrix got %0d want %0d",
                                  out_first_matrix, want.first_mat));
        if (out_last_matrix !== want.last_mat)
          flag_mismatch($sformatf("last_matrix got %0d want %0d",
                                  out_last_matrix, want.last_mat));
        if (out_min_cost !== want.cost)
          flag_mismatch($sformatf("min_cost %0d..%0d got %0d want %0d", want.first_mat,
                                  want.last_mat, out_min_cost, want.cost));
        if (out_best_split !== want.split)
          flag_mismatch($sformatf("best_split %0d..%0d got %0d want %0d", want.first_mat,
                                  want.last_mat, out_best_split, want.split));
        if (out_end_of_run !== want.eor)
          flag_mismatch($sformatf("end_of_run %0d..%0d got %0b want %0b", want.first_mat,
                                  want.last_mat, out_end_of_run, want.eor));
        if (out_overflow !== want.ovf)
          flag_mismatch($sformatf("overflow %0d..%0d got %0b want %0b", want.first_mat,
                                  want.last_mat, out_overflow, want.ovf));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_intervals.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    int len;
    int r;
    held_count        = 0;
    held_ovf          = 1'b0;
    beats_taken       = 0;
    chains_closed     = 0;
    overflow_chains   = 0;
    intervals_checked = 0;
    error_count       = 0;
    cycle_count       = 0;
    idle_left         = 0;
    rst_n             = 1'b0;

    push_beat(8'd7, 1'b1, 0, 1'b0);
    push_beat(8'd255, 1'b0, 0, 1'b0);
    push_beat(8'd1, 1'b1, 2, 1'b0);
    for (int i = 0; i < 4; i++) push_beat(8'd1, i == 3, 0, 1'b0);
    push_beat(8'd255, 1'b0, 1, 1'b0);
    push_beat(8'd0, 1'b0, 0, 1'b0);
    push_beat(8'd255, 1'b1, 0, 1'b0);
    for (int i = 0; i < SIDE + 1; i++)
      push_beat((i % 2) ? 8'd1 : 8'd255, i == SIDE, i % 3, i == 0);

    while (dimension_beats.size() < 180) begin
      r = $urandom_range(0, 99);
      if (r < 70)      len = $urandom_range(3, SIDE);
      else if (r < 85) len = $urandom_range(1, 2);
      else             len = $urandom_range(SIDE + 1, SIDE + 3);
      queue_chain(len, $urandom_range(0, 9) == 0);
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (dimension_beats.size() > 0 || start || pending_intervals.size() > 0)
      @(posedge clk);
    repeat (TAIL) @(posedge clk);

    $display("covered %0d dimension beats in %0d chains (%0d over capacity)",
             beats_taken, chains_closed, overflow_chains);
    $display("checked %0d interval results, %0d mismatches", intervals_checked, error_count);
    if (error_count == 0 && pending_intervals.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
